// File: hw/rtl/frame_timer_network_discipline_defines.svh
// ----------------------------------------------------------------------------
// Frame timer assertion macros
// Shared property forms for the frame timer checkers, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIMER_NETWORK_DISCIPLINE_DEFINES_SVH
`define FRAME_TIMER_NETWORK_DISCIPLINE_DEFINES_SVH

// same-cycle implication
`define FTND_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTND_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ftnd_pkg.sv
// ----------------------------------------------------------------------------
// Frame timer package
// Types, widths and the period step table shared by the frame timer modules.
// ----------------------------------------------------------------------------
package ftnd_pkg;

  localparam int FRAME_W  = 16;
  localparam int NET_W    = 32;
  localparam int MCAND_W  = 32;
  localparam int DIVR_W   = 16;
  localparam int CORR_LO  = 16;

  localparam logic [FRAME_W-1:0] BASE_PERIOD_RESET = 16'd7812;
  localparam logic [DIVR_W-1:0]  MS_PER_S          = 16'd1000;
  localparam logic [1:0]         STROBE_PHASE      = 2'b00;

  localparam logic signed [FRAME_W:0] SYNC_LIMIT = 17'sd3;

  localparam logic signed [FRAME_W-1:0] ERR_HUGE  = 16'sd1000;
  localparam logic signed [FRAME_W-1:0] ERR_LARGE = 16'sd200;
  localparam logic signed [FRAME_W-1:0] ERR_MID   = 16'sd100;
  localparam logic signed [FRAME_W-1:0] ERR_SMALL = 16'sd10;

  localparam logic signed [FRAME_W-1:0] STEP_HUGE  = 16'sd200;
  localparam logic signed [FRAME_W-1:0] STEP_LARGE = 16'sd30;
  localparam logic signed [FRAME_W-1:0] STEP_MID   = 16'sd10;
  localparam logic signed [FRAME_W-1:0] STEP_SMALL = 16'sd5;
  localparam logic signed [FRAME_W-1:0] STEP_NONE  = 16'sd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORR,
    S_CORR_W,
    S_TICKS,
    S_TICKS_W,
    S_DIV1,
    S_DIV1_W,
    S_DIV2,
    S_DIV2_W,
    S_FIN,
    S_OUT
  } state_t;

  function automatic logic signed [FRAME_W-1:0] period_step(
    input logic signed [FRAME_W-1:0] e
  );
    logic signed [FRAME_W-1:0] s;
    begin
      if (e > ERR_HUGE)        s = -STEP_HUGE;
      else if (e > ERR_LARGE)  s = -STEP_LARGE;
      else if (e > ERR_MID)    s = -STEP_MID;
      else if (e > ERR_SMALL)  s = -STEP_SMALL;
      else if (e < -ERR_HUGE)  s = STEP_HUGE;
      else if (e < -ERR_LARGE) s = STEP_LARGE;
      else if (e < -ERR_MID)   s = STEP_MID;
      else if (e < -ERR_SMALL) s = STEP_SMALL;
      else                     s = STEP_NONE;
      return s;
    end
  endfunction

endpackage

// File: hw/rtl/frame_timer_network_discipline.sv
// ----------------------------------------------------------------------------
// Frame timer disciplined to a network clock
// Input channel in_valid/in_ready carries one beat per event: op 0 is a
// compare tick, op 1 a discipline check. Output channel out_valid/out_ready
// carries one result beat per input beat, in order. cfg_wen/cfg_wdata write
// base_period at any edge; no handshake.
// For a tick the state goes straight to S_OUT, and out_valid is set from
// there once the output register is free. A check runs the shift-add
// multiplier (three passes, one of them overlapped with the first divide)
// and the restoring divider (PW bits for the ms-to-ticks scale, 32 bits for
// the network frame), each one bit/cycle; MW is the multiplier width (max of
// 16 and the tick rate width) and PW = 32 + MW.
// One beat is in work at a time; a new beat is accepted while the previous
// result waits in the output register. If the receiver stalls, the result
// holds and the next result waits in its final state until the register
// frees. Reset clears frame and compare to 0 and sets base and period to
// 7812.
// ----------------------------------------------------------------------------
module frame_timer_network_discipline #(
  parameter int unsigned TICK_RATE_HZ = 31250
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [15:0]        timer_count,
  input  logic [31:0]        net_base_ms,
  input  logic [30:0]        elapsed_ms,
  input  logic signed [15:0] drift,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               strobe_res,
  output logic [15:0]        frame_count,
  output logic [15:0]        compare_value,
  output logic [15:0]        period_out,
  output logic signed [15:0] phase_error,
  output logic               hard_sync
);
  import ftnd_pkg::*;

  localparam int RATE_W = $clog2(TICK_RATE_HZ + 1);
  localparam int MW     = (RATE_W > 16) ? RATE_W : 16;
  localparam int PW     = NET_W + MW;
  localparam int SW     = $clog2(PW + 1);

  state_t state;
  state_t state_next;

  logic [FRAME_W-1:0] base_period;
  logic [FRAME_W-1:0] frame_counter;
  logic [FRAME_W-1:0] period_reg;
  logic [FRAME_W-1:0] compare_reg;

  logic [FRAME_W-1:0]        tcnt_q;
  logic [NET_W-1:0]          nbase_q;
  logic [30:0]               elapsed_q;
  logic signed [FRAME_W-1:0] drift_q;
  logic                      strobe_q;
  logic                      hard_q;
  logic [FRAME_W-1:0]        phase_q;

  logic               mul_start;
  logic [MCAND_W-1:0] mul_mcand;
  logic [MW-1:0]      mul_mplier;
  logic               mul_done;
  logic [PW-1:0]      mul_prod;

  logic              div_start;
  logic [PW-1:0]     div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic [SW-1:0]     div_steps;
  logic              div_done;
  logic [PW-1:0]     div_quot;

  logic [FRAME_W-1:0]      drift_mag;
  logic [NET_W-1:0]        corr_mag;
  logic [NET_W-1:0]        base_sum;
  logic [NET_W-1:0]        net_ms;
  logic [FRAME_W-1:0]      el_ticks;
  logic [FRAME_W-1:0]      phase_next;
  logic [FRAME_W-1:0]      frame_inc;
  logic [FRAME_W-1:0]      sync_frame;
  logic signed [FRAME_W:0] fdiff;
  logic                    far_off;
  logic                    out_free;

  ftnd_mul #(.MW(MW)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  ftnd_div #(.DW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign drift_mag  = drift_q[FRAME_W-1] ? (~drift_q + 1'b1) : drift_q;
  assign corr_mag   = mul_prod[CORR_LO+NET_W-1:CORR_LO];
  assign base_sum   = nbase_q + {1'b0, elapsed_q};
  assign net_ms     = drift_q[FRAME_W-1] ? (base_sum + corr_mag) : (base_sum - corr_mag);
  assign el_ticks   = tcnt_q - (compare_reg - base_period);
  assign phase_next = div_quot[FRAME_W-1:0] - mul_prod[FRAME_W-1:0] - el_ticks;
  assign frame_inc  = frame_counter + 1'b1;
  assign sync_frame = div_quot[FRAME_W-1:0];
  assign fdiff      = $signed({1'b0, frame_counter}) - $signed({1'b0, sync_frame});
  assign far_off    = (fdiff > SYNC_LIMIT) || (fdiff < -SYNC_LIMIT);
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = op ? S_CORR : S_OUT;
      end
      S_CORR:    state_next = S_CORR_W;
      S_CORR_W:  if (mul_done) state_next = S_TICKS;
      S_TICKS:   state_next = S_TICKS_W;
      S_TICKS_W: if (mul_done) state_next = S_DIV1;
      S_DIV1:    state_next = S_DIV1_W;
      S_DIV1_W:  if (div_done) state_next = S_DIV2;
      S_DIV2:    state_next = S_DIV2_W;
      S_DIV2_W:  if (div_done) state_next = S_FIN;
      S_FIN:     state_next = S_OUT;
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    mul_start    = 1'b0;
    mul_mcand    = {1'b0, elapsed_q};
    mul_mplier   = MW'(drift_mag);
    div_start    = 1'b0;
    div_dividend = mul_prod;
    div_divisor  = MS_PER_S;
    div_steps    = SW'(PW);
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_CORR: mul_start = 1'b1;
      S_TICKS: begin
        mul_start  = 1'b1;
        mul_mcand  = net_ms;
        mul_mplier = MW'(TICK_RATE_HZ);
      end
      S_DIV1: begin
        mul_start  = 1'b1;
        mul_mcand  = MCAND_W'(frame_counter);
        mul_mplier = MW'(base_period);
        div_start  = 1'b1;
      end
      S_DIV2: begin
        div_start    = 1'b1;
        div_dividend = {div_quot[NET_W-1:0], {MW{1'b0}}};
        div_divisor  = base_period;
        div_steps    = SW'(NET_W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      base_period   <= BASE_PERIOD_RESET;
      frame_counter <= '0;
      period_reg    <= BASE_PERIOD_RESET;
      compare_reg   <= '0;
    end else begin
      state <= state_next;
      if (cfg_wen) base_period <= cfg_wdata;
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tcnt_q    <= timer_count;
            nbase_q   <= net_base_ms;
            elapsed_q <= elapsed_ms;
            drift_q   <= drift;
            strobe_q  <= !op && (frame_inc[1:0] == STROBE_PHASE);
            hard_q    <= 1'b0;
            phase_q   <= '0;
            if (!op) begin
              frame_counter <= frame_inc;
              compare_reg   <= compare_reg + period_reg;
            end
          end
        end
        S_DIV2: phase_q <= phase_next;
        S_FIN: begin
          hard_q     <= far_off;
          period_reg <= base_period + period_step($signed(phase_q));
          if (far_off) begin
            frame_counter <= sync_frame;
            compare_reg   <= tcnt_q + base_period;
          end
        end
        S_OUT: begin
          if (out_free) begin
            strobe_res    <= strobe_q;
            frame_count   <= frame_counter;
            compare_value <= compare_reg;
            period_out    <= period_reg;
            phase_error   <= phase_q;
            hard_sync     <= hard_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/ftnd_mul.sv
// ----------------------------------------------------------------------------
// Frame timer serial multiplier
// Shift-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ftnd_mul #(
  parameter int MW = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ftnd_pkg::MCAND_W-1:0]      mcand,
  input  logic [MW-1:0]                     mplier,
  output logic                              done,
  output logic [ftnd_pkg::MCAND_W+MW-1:0]   prod
);
  import ftnd_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [MCAND_W-1:0] mcand_q;
  logic [MCAND_W-1:0] hi;
  logic [MW-1:0]      lo;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic [MCAND_W:0]   sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand_q} : {(MCAND_W+1){1'b0}});
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(MW - 1));
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        hi      <= '0;
        lo      <= mplier;
        mcand_q <= mcand;
      end else if (busy) begin
        hi  <= sum[MCAND_W:1];
        lo  <= {sum[0], lo[MW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ftnd_div.sv
// ----------------------------------------------------------------------------
// Frame timer serial divider
// Restoring divider that retires one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ftnd_div #(
  parameter int DW = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [ftnd_pkg::DIVR_W-1:0]   divisor,
  input  logic [$clog2(DW+1)-1:0]       steps,
  output logic                          done,
  output logic [DW-1:0]                 quot
);
  import ftnd_pkg::*;

  localparam int SW = $clog2(DW + 1);

  logic [DW-1:0]     d;
  logic [DIVR_W-1:0] r;
  logic [DIVR_W-1:0] dv;
  logic [SW-1:0]     cnt;
  logic              busy;
  logic [DIVR_W:0]   r2;
  logic [DIVR_W:0]   diff;
  logic              ge;

  assign r2   = {r, d[DW-1]};
  assign ge   = r2 >= {1'b0, dv};
  assign diff = r2 - {1'b0, dv};
  assign quot = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == SW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
        d    <= dividend;
        r    <= '0;
        dv   <= divisor;
      end else if (busy) begin
        r   <= ge ? diff[DIVR_W-1:0] : r2[DIVR_W-1:0];
        d   <= {d[DW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ftnd_chk.sv
// ----------------------------------------------------------------------------
// Frame timer port checker
// Watches the frame timer ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "frame_timer_network_discipline_defines.svh"

module ftnd_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               strobe_res,
  input logic [15:0]        frame_count,
  input logic [15:0]        compare_value,
  input logic [15:0]        period_out,
  input logic signed [15:0] phase_error,
  input logic               hard_sync
);

  `FTND_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(frame_count) && $stable(compare_value) && $stable(period_out),
    "result beat dropped or changed while stalled")

  `FTND_ASSERT_NOW(a_strobe_frame, out_valid && strobe_res, frame_count[1:0] == 2'b00,
    "strobe on a frame not a multiple of four")

  `FTND_ASSERT_NOW(a_strobe_tick, out_valid && strobe_res,
    phase_error == 16'sd0 && !hard_sync, "strobe beat carries check results")

  `FTND_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
    "second beat accepted while one is in work")

endmodule

bind frame_timer_network_discipline ftnd_chk u_ftnd_chk (.*);

// File: bench/ftnd_bench_pkg.sv
// ----------------------------------------------------------------------------
// Frame timer bench codes
// Operation codes of the input beat, used by the stimulus and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package ftnd_bench_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

endpackage

// File: bench/frame_timer_checker.sv
// ----------------------------------------------------------------------------
// Frame timer result checker
// Watches the config port and both channels, keeps its own copy of the frame
// number, compare value, period and base period, predicts the result of every
// accepted input beat and compares each result beat, in order, with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module frame_timer_checker #(
  parameter int unsigned TICK_RATE_HZ = 31250
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic [15:0]        timer_count,
  input  logic [31:0]        net_base_ms,
  input  logic [30:0]        elapsed_ms,
  input  logic signed [15:0] drift,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               strobe_res,
  input  logic [15:0]        frame_count,
  input  logic [15:0]        compare_value,
  input  logic [15:0]        period_out,
  input  logic signed [15:0] phase_error,
  input  logic               hard_sync,
  output int                 mismatches,
  output int                 outstanding
);
  import ftnd_pkg::*;
  import ftnd_bench_pkg::*;

  typedef struct packed {
    logic               strobe;
    logic [15:0]        frame;
    logic [15:0]        compare;
    logic [15:0]        period;
    logic signed [15:0] phase;
    logic               hard;
  } frame_beat_t;

  frame_beat_t expected_q[$];
  logic [15:0] base_now;
  logic [15:0] frame_no;
  logic [15:0] cmp_val;
  logic [15:0] period_now;
  int          fails = 0;
  int          beat_no = 0;

  assign mismatches = fails;

  function automatic int rate_step(input logic signed [15:0] e);
    if (e > ERR_HUGE)        return -int'(STEP_HUGE);
    if (e > ERR_LARGE)       return -int'(STEP_LARGE);
    if (e > ERR_MID)         return -int'(STEP_MID);
    if (e > ERR_SMALL)       return -int'(STEP_SMALL);
    if (e < -ERR_HUGE)       return int'(STEP_HUGE);
    if (e < -ERR_LARGE)      return int'(STEP_LARGE);
    if (e < -ERR_MID)        return int'(STEP_MID);
    if (e < -ERR_SMALL)      return int'(STEP_SMALL);
    return 0;
  endfunction

  function automatic frame_beat_t predict_frame_step(
    input logic               o,
    input logic [15:0]        tc,
    input logic [31:0]        nb,
    input logic [30:0]        em,
    input logic signed [15:0] dr
  );
    frame_beat_t r;
    longint      corr;
    logic [31:0] net_ms;
    logic [31:0] net_ticks;
    logic [31:0] local_ticks;
    logic [15:0] el_ticks;
    logic [15:0] sync_frame;
    logic [15:0] ph;
    int          diff;
    r = '0;
    if (o == OP_TICK) begin
      frame_no = frame_no + 16'd1;
      cmp_val  = cmp_val + period_now;
      r.strobe = (frame_no[1:0] == STROBE_PHASE);
    end else begin
      corr        = (longint'(dr) * longint'(em)) / 65536;
      net_ms      = nb + 32'(longint'(em) - corr);
      net_ticks   = 32'((64'(net_ms) * 64'(TICK_RATE_HZ)) / 64'd1000);
      el_ticks    = tc - (cmp_val - base_now);
      local_ticks = 32'(frame_no) * 32'(base_now) + 32'(el_ticks);
      ph          = 16'(net_ticks - local_ticks);
      sync_frame  = (base_now == 16'd0) ? 16'hFFFF : 16'(net_ticks / 32'(base_now));
      diff        = int'({16'd0, frame_no}) - int'({16'd0, sync_frame});
      if (diff < 0) diff = -diff;
      if (diff > 3) begin
        frame_no = sync_frame;
        cmp_val  = tc + base_now;
        r.hard   = 1'b1;
      end
      period_now = 16'(int'({16'd0, base_now}) + rate_step(ph));
      r.phase    = ph;
    end
    r.frame   = frame_no;
    r.compare = cmp_val;
    r.period  = period_now;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    frame_beat_t want;
    frame_beat_t got;
    if (rst) begin
      base_now   = BASE_PERIOD_RESET;
      frame_no   = 16'd0;
      cmp_val    = 16'd0;
      period_now = BASE_PERIOD_RESET;
      expected_q.delete();
    end else begin
      if (cfg_wen) base_now = cfg_wdata;
      if (out_valid && out_ready) begin
        got = {strobe_res, frame_count, compare_value, period_out, phase_error, hard_sync};
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("result beat %0d arrived with nothing expected", beat_no);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("beat %0d exp/got: strobe %0b/%0b frame %0d/%0d compare %0d/%0d ",
                       beat_no, want.strobe, got.strobe, want.frame, got.frame,
                       want.compare, got.compare,
                       "period %0d/%0d phase %0d/%0d hard %0b/%0b",
                       want.period, got.period, $signed(want.phase), $signed(got.phase),
                       want.hard, got.hard);
          end
        end
        beat_no++;
      end
      if (in_valid && in_ready)
        expected_q.push_back(predict_frame_step(op, timer_count, net_base_ms, elapsed_ms,
                                                drift));
    end
    outstanding <= expected_q.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Frame timer testbench
// Drives tick and check beats through frame_timer_network_discipline under
// several base periods, with random gaps on the sender and random stalls on
// the receiver. Checks are mostly built near lock from the last observed
// frame and compare values so that every band of the period table and both
// sides of the hard sync limit are reached; the rest carry random fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb;
  import ftnd_bench_pkg::*;

  localparam int unsigned TICK_HZ = 31250;
  localparam int PHASE_ITEMS = 272;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wen = 1'b0;
  logic [15:0]        cfg_wdata = 16'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = OP_TICK;
  logic [15:0]        timer_count = 16'd0;
  logic [31:0]        net_base_ms = 32'd0;
  logic [30:0]        elapsed_ms = 31'd0;
  logic signed [15:0] drift = 16'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               strobe_res;
  logic [15:0]        frame_count;
  logic [15:0]        compare_value;
  logic [15:0]        period_out;
  logic signed [15:0] phase_error;
  logic               hard_sync;

  int          mismatches;
  int          outstanding;
  logic [15:0] seen_frame = 16'd0;
  logic [15:0] seen_compare = 16'd0;
  logic [15:0] base_now = 16'd7812;
  int          hard_seen = 0;
  int          items_sent = 0;
  int          checks_sent = 0;
  int          settings_used = 1;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          rx_hold = 0;
  int          lock_err[9] = '{0, 50, 150, 500, 1500, -50, -150, -500, -1500};

  frame_timer_network_discipline #(.TICK_RATE_HZ(TICK_HZ)) dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .timer_count(timer_count),
    .net_base_ms(net_base_ms), .elapsed_ms(elapsed_ms), .drift(drift),
    .out_valid(out_valid), .out_ready(out_ready), .strobe_res(strobe_res),
    .frame_count(frame_count), .compare_value(compare_value), .period_out(period_out),
    .phase_error(phase_error), .hard_sync(hard_sync)
  );

  frame_timer_checker #(.TICK_RATE_HZ(TICK_HZ)) u_check (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .timer_count(timer_count),
    .net_base_ms(net_base_ms), .elapsed_ms(elapsed_ms), .drift(drift),
    .out_valid(out_valid), .out_ready(out_ready), .strobe_res(strobe_res),
    .frame_count(frame_count), .compare_value(compare_value), .period_out(period_out),
    .phase_error(phase_error), .hard_sync(hard_sync),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #30000000;
    $display("FAIL frame_timer_network_discipline");
    $finish;
  end

  function automatic int burst_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic int send_gap();
    if (tx_calm || $urandom_range(0, 99) < 60) return 0;
    return burst_gap();
  endfunction

  // stall the receiver at random, with calm stretches
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 18) begin
      rx_hold = burst_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 599) == 0) rx_calm = !rx_calm;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_frame   <= frame_count;
      seen_compare <= compare_value;
      if (hard_sync) hard_seen++;
    end
  end

  task automatic send_beat(
    input logic               o,
    input logic [15:0]        tc,
    input logic [31:0]        nb,
    input logic [30:0]        em,
    input logic signed [15:0] dr,
    input int                 gap
  );
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    timer_count <= tc;
    net_base_ms <= nb;
    elapsed_ms  <= em;
    drift       <= dr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (o == OP_CHECK) checks_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [15:0] v);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    base_now  = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    settings_used++;
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, 16'($urandom()), $urandom(), 31'($urandom()), 16'($urandom()),
              send_gap());
  endtask

  task automatic send_raw_check();
    send_beat(OP_CHECK, 16'($urandom()), $urandom(), 31'($urandom()), 16'($urandom()),
              send_gap());
  endtask

  // build a check whose network time lands err_target ticks off the local
  // frame time, shifted by frame_skew whole frames
  task automatic locked_check(input int err_target, input int frame_skew);
    logic [15:0]        last_cc;
    logic [15:0]        tc;
    logic signed [15:0] dr;
    longint             target;
    longint             nms;
    longint             corr;
    int                 em;
    wait_idle();
    last_cc = seen_compare - base_now;
    if (base_now == 16'd0) tc = 16'($urandom());
    else tc = last_cc + 16'($urandom_range(0, int'(base_now) - 1));
    target = longint'(seen_frame) * longint'(base_now) + longint'(16'(tc - last_cc))
             + err_target + longint'(frame_skew) * longint'(base_now);
    if (target < 0) target = 0;
    nms = (target * 4 + 62) / 125;
    em  = ($urandom_range(0, 9) == 0) ? int'($urandom() >> 1) : $urandom_range(0, 4000000);
    dr  = 16'($urandom());
    corr = (longint'(dr) * longint'(em)) / 65536;
    send_beat(OP_CHECK, tc, 32'(nms - em + corr), 31'(em), dr, send_gap());
  endtask

  initial begin
    logic [15:0] phase_base[6];
    int          err;
    int          skew;
    int          r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    repeat (4) send_beat(OP_TICK, 16'd0, 32'd0, 31'd0, 16'sd0, 0);
    send_beat(OP_CHECK, 16'd0, 32'd0, 31'd0, 16'sd0, 0);
    send_beat(OP_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'sh7FFF, 0);
    send_beat(OP_CHECK, 16'd0, 32'd0, 31'h7FFF_FFFF, 16'sh8000, 0);
    foreach (lock_err[i])
      locked_check(lock_err[i], 0);
    locked_check(0, 9);

    // zero base period saturates the network frame
    write_base(16'd0);
    send_beat(OP_CHECK, 16'h1234, 32'd5000, 31'd1000, 16'sd100, 0);
    send_beat(OP_TICK, 16'd0, 32'd0, 31'd0, 16'sd0, 0);

    phase_base = '{16'd1, 16'd65535, 16'($urandom_range(2, 300)),
                   16'($urandom_range(301, 65534)), 16'd7812, 16'($urandom_range(1, 65535))};
    foreach (phase_base[p]) begin
      write_base(phase_base[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 79) == 0) tx_calm = !tx_calm;
        r = $urandom_range(0, 99);
        if (r < 55) begin
          send_tick();
        end else if (r < 80) begin
          if ($urandom_range(0, 9) < 3) err = int'($urandom_range(0, 60)) - 30;
          else err = int'($urandom_range(0, 2800)) - 1400;
          skew = 0;
          if ($urandom_range(0, 9) == 0)
            skew = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(4, 12));
          locked_check(err, skew);
        end else begin
          send_raw_check();
        end
      end
    end

    wait_idle();
    repeat (150) @(posedge clk);
    $display("covered %0d beats (%0d checks, %0d hard syncs) over %0d base period settings",
             items_sent, checks_sent, hard_seen, settings_used);
    $display("mismatches: %0d, results still expected: %0d", mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS frame_timer_network_discipline");
    end else begin
      $display("FAIL frame_timer_network_discipline");
    end
    $finish;
  end

endmodule
